// ===== rtl/tgs_pkg.sv =====
package tgs_pkg;

  localparam int MAX_SIDE   = 32;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int SIDE_LEN_W = $clog2(MAX_SIDE + 1);
  localparam int PLANE_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int COUNT_W    = $clog2(MAX_SIDE * MAX_SIDE * MAX_SIDE + 1);

  // ring lengths: plane minus one row, and one row minus one voxel
  localparam int RA_DEPTH = MAX_SIDE * (MAX_SIDE - 1);
  localparam int RA_AW    = $clog2(RA_DEPTH);
  localparam int RB_DEPTH = MAX_SIDE - 1;
  localparam int RB_AW    = $clog2(RB_DEPTH);

  localparam int CFG_DATA_W = 16;
  localparam int T_W        = 16;
  localparam int WORD_W     = 2 * T_W;
  localparam int OUT_W      = 32;
  localparam int NRES       = 10;

  localparam int DIFF_W   = T_W + 1;
  localparam int LAP_W    = T_W + 4;
  localparam int Q_W      = CFG_DATA_W + 1;
  localparam int PROD_W   = DIFF_W + Q_W;
  localparam int LAPQ_W   = LAP_W + Q_W;
  localparam int SAT_IN_W = LAPQ_W + Q_W;
  localparam int LAP_SHIFT = 9;

  localparam logic [SIDE_LEN_W-1:0] SIDE_RST  = SIDE_LEN_W'(MAX_SIDE);
  localparam logic [CFG_DATA_W-1:0] INV_H_RST = CFG_DATA_W'(256);
  localparam int                    SIDE_MIN  = 3;

  typedef enum logic {
    CFG_GRID_SIDE = 1'b0,
    CFG_INV_CELL  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [T_W-1:0] c;
    logic signed [T_W-1:0] xp;
    logic signed [T_W-1:0] xm;
    logic signed [T_W-1:0] yp;
    logic signed [T_W-1:0] ym;
    logic signed [T_W-1:0] zp;
    logic signed [T_W-1:0] zm;
    logic                  last;
  } sten_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(33'sh0_7FFF_FFFF);
    lo = SAT_IN_W'(33'sh1_8000_0000);
    if (v > hi) begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/temperature_gradient_stencil.sv =====
// Seven-point temperature stencil over a streamed cubic voxel grid.
// in_*  : one voxel item per handshake in raster order (x fastest, then y,
//         then z); in_tuser = 1 marks a flush item used to drain the last
//         plane once the whole grid has arrived.
// out_* : one result item per reported voxel: central, forward and backward
//         differences on each axis and the Laplacian, Q16.16 saturated;
//         out_tlast marks the final voxel of the grid.
// cfg_* : register writes (index 0 grid side, index 1 inverse cell size);
//         always ready. The user must write them only while the block is idle;
//         the block does not enforce this. A grid side write restarts the frame.
// Throughput is one item per cycle until a stalled output fills the pipeline: the
// plane window lives in four ring memories (two of a plane less a row, two of a
// row less one voxel) and each ring does one read and one write per item.
// Results follow one plane behind the input; a reporting item's result is
// registered through the pipeline stages before it shows on out_*.
// Reset clears the frame counters and sets side 32, inverse cell size 1.0;
// ring contents are left as they are. When out_tready is low the five
// pipeline stages keep taking items until all hold one, then in_tready drops.
module temperature_gradient_stencil (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [31:0]                             in_tdata,  // temperature, ambient
  input  logic                                    in_tuser,  // op
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // central_dx, central_dy, central_dz, forward_dx, forward_dy, forward_dz,
  // backward_dx, backward_dy, backward_dz, laplacian
  output logic [tgs_pkg::NRES*tgs_pkg::OUT_W-1:0] out_tdata,
  output logic                                    out_tlast, // last_of_frame
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic                                    cfg_index,
  input  logic [tgs_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import tgs_pkg::*;

  logic                  acc;
  logic                  emit;
  logic                  rdy;
  sten_t                 sten;
  logic [CFG_DATA_W-1:0] inv_h;

  assign cfg_ready = 1'b1;
  assign in_tready = rdy;
  assign acc       = in_tvalid && rdy;

  tgs_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_valid),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .acc     (acc),
    .op      (in_tuser),
    .temp    (in_tdata[T_W-1:0]),
    .amb     (in_tdata[WORD_W-1:T_W]),
    .sten    (sten),
    .emit    (emit),
    .inv_h   (inv_h)
  );

  tgs_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .emit      (emit),
    .sten      (sten),
    .inv_h     (inv_h),
    .rdy       (rdy),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (out_tdata),
    .res_last  (out_tlast)
  );

endmodule

// ===== rtl/tgs_ram.sv =====
module tgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tgs_window.sv =====
module tgs_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr,
  input  logic                              cfg_idx,
  input  logic [tgs_pkg::CFG_DATA_W-1:0]    cfg_val,
  input  logic                              acc,
  input  logic                              op,
  input  logic [tgs_pkg::T_W-1:0]           temp,
  input  logic [tgs_pkg::T_W-1:0]           amb,
  output tgs_pkg::sten_t                    sten,
  output logic                              emit,
  output logic [tgs_pkg::CFG_DATA_W-1:0]    inv_h
);
  import tgs_pkg::*;

  logic [SIDE_W-1:0]     side_m1_r;
  logic [PLANE_W-1:0]    plane_r;
  logic [COUNT_W-1:0]    total_r;
  logic [RA_AW-1:0]      a_last_r;
  logic [RB_AW-1:0]      b_last_r;
  logic [CFG_DATA_W-1:0] inv_h_r;

  logic [COUNT_W-1:0] recv_r, recv_nxt;
  logic [SIDE_W-1:0]  ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;

  logic [RA_AW-1:0] pa_r, pa_nxt, pd_r, pd_nxt;
  logic [RB_AW-1:0] pb_r, pb_nxt, pc_r, pc_nxt;

  logic [WORD_W-1:0] a_rd, b_rd, c_r;
  logic [T_W-1:0]    c_rd, d_rd, xm_r;

  logic samp_ok, flush_ok, shift, last, restart;
  logic side_wr;
  logic [SIDE_LEN_W-1:0] sv;
  logic [PLANE_W-1:0]    pv;

  // clamp of the grid side and the derived lengths
  always_comb begin
    sv = cfg_val[SIDE_LEN_W-1:0];
    if (int'(cfg_val[5:0]) < SIDE_MIN) begin
      sv = SIDE_LEN_W'(SIDE_MIN);
    end else if (int'(cfg_val[5:0]) > MAX_SIDE) begin
      sv = SIDE_LEN_W'(MAX_SIDE);
    end else begin
      sv = SIDE_LEN_W'(cfg_val[5:0]);
    end
    pv = PLANE_W'(sv) * PLANE_W'(sv);
  end

  assign side_wr = cfg_wr && (cfg_idx == CFG_GRID_SIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_m1_r <= SIDE_W'(MAX_SIDE - 1);
      plane_r   <= PLANE_W'(MAX_SIDE * MAX_SIDE);
      total_r   <= COUNT_W'(MAX_SIDE * MAX_SIDE * MAX_SIDE);
      a_last_r  <= RA_AW'(RA_DEPTH - 1);
      b_last_r  <= RB_AW'(RB_DEPTH - 1);
      inv_h_r   <= INV_H_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == CFG_GRID_SIDE) begin
        side_m1_r <= SIDE_W'(sv - 1'b1);
        plane_r   <= pv;
        total_r   <= COUNT_W'(pv) * COUNT_W'(sv);
        a_last_r  <= RA_AW'(pv - PLANE_W'(sv) - 1'b1);
        b_last_r  <= RB_AW'(sv - 2'd2);
      end else begin
        inv_h_r <= cfg_val;
      end
    end
  end

  assign inv_h = inv_h_r;

  // frame control
  assign samp_ok  = (op == OP_SAMPLE) && (recv_r != total_r);
  assign flush_ok = (op == OP_FLUSH) && (recv_r == total_r);
  assign shift    = acc && (samp_ok || flush_ok);
  assign emit     = acc && ((samp_ok && (recv_r >= COUNT_W'(plane_r))) || flush_ok);
  assign last     = (ox_r == side_m1_r) && (oy_r == side_m1_r) && (oz_r == side_m1_r);
  assign restart  = side_wr || (emit && last);

  always_comb begin
    recv_nxt = recv_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    if (restart) begin
      recv_nxt = '0;
      ox_nxt   = '0;
      oy_nxt   = '0;
      oz_nxt   = '0;
    end else begin
      if (shift && samp_ok) begin
        recv_nxt = recv_r + 1'b1;
      end
      if (emit) begin
        if (ox_r == side_m1_r) begin
          ox_nxt = '0;
          if (oy_r == side_m1_r) begin
            oy_nxt = '0;
            oz_nxt = oz_r + 1'b1;
          end else begin
            oy_nxt = oy_r + 1'b1;
          end
        end else begin
          ox_nxt = ox_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      oz_r   <= '0;
    end else begin
      recv_r <= recv_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
    end
  end

  // ring pointers; each ring reads ahead at the next pointer so its oldest
  // entry is ready on the cycle of the shift
  always_comb begin
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    pc_nxt = pc_r;
    pd_nxt = pd_r;
    if (side_wr) begin
      pa_nxt = '0;
      pb_nxt = '0;
      pc_nxt = '0;
      pd_nxt = '0;
    end else if (shift) begin
      pa_nxt = (pa_r == a_last_r) ? '0 : pa_r + 1'b1;
      pd_nxt = (pd_r == a_last_r) ? '0 : pd_r + 1'b1;
      pb_nxt = (pb_r == b_last_r) ? '0 : pb_r + 1'b1;
      pc_nxt = (pc_r == b_last_r) ? '0 : pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= '0;
      pb_r <= '0;
      pc_r <= '0;
      pd_r <= '0;
    end else begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
      pd_r <= pd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      c_r  <= b_rd;
      xm_r <= c_r[T_W-1:0];
    end
  end

  tgs_ram #(.WIDTH(WORD_W), .DEPTH(RA_DEPTH)) u_ring_a (
    .clk(clk), .we(shift), .waddr(pa_r), .wdata({amb, temp}),
    .raddr(pa_nxt), .rdata(a_rd)
  );

  tgs_ram #(.WIDTH(WORD_W), .DEPTH(RB_DEPTH)) u_ring_b (
    .clk(clk), .we(shift), .waddr(pb_r), .wdata(a_rd),
    .raddr(pb_nxt), .rdata(b_rd)
  );

  tgs_ram #(.WIDTH(T_W), .DEPTH(RB_DEPTH)) u_ring_c (
    .clk(clk), .we(shift), .waddr(pc_r), .wdata(xm_r),
    .raddr(pc_nxt), .rdata(c_rd)
  );

  tgs_ram #(.WIDTH(T_W), .DEPTH(RA_DEPTH)) u_ring_d (
    .clk(clk), .we(shift), .waddr(pd_r), .wdata(c_rd),
    .raddr(pd_nxt), .rdata(d_rd)
  );

  // taps: input is +z, ring a +y, ring b +x, c_r centre, xm_r -x,
  // ring c -y, ring d -z; off-grid neighbours take the centre ambient
  always_comb begin
    sten.c    = c_r[T_W-1:0];
    sten.xp   = (ox_r != side_m1_r) ? b_rd[T_W-1:0] : c_r[WORD_W-1:T_W];
    sten.xm   = (ox_r != '0)        ? xm_r          : c_r[WORD_W-1:T_W];
    sten.yp   = (oy_r != side_m1_r) ? a_rd[T_W-1:0] : c_r[WORD_W-1:T_W];
    sten.ym   = (oy_r != '0)        ? c_rd          : c_r[WORD_W-1:T_W];
    sten.zp   = (oz_r != side_m1_r) ? temp          : c_r[WORD_W-1:T_W];
    sten.zm   = (oz_r != '0)        ? d_rd          : c_r[WORD_W-1:T_W];
    sten.last = last;
  end

  a_recv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    recv_r <= total_r)
    else $error("received count beyond grid");

  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last |-> op == OP_FLUSH)
    else $error("final voxel reported on a sample");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pa_r <= a_last_r && pb_r <= b_last_r && pc_r <= b_last_r && pd_r <= a_last_r)
    else $error("ring pointer past its length");

  a_ptr_lock: assert property (@(posedge clk) disable iff (!rst_n)
    pa_r == pd_r && pb_r == pc_r)
    else $error("paired rings out of step");

endmodule

// ===== rtl/tgs_arith.sv =====
module tgs_arith (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic                             emit,
  input  tgs_pkg::sten_t                   sten,
  input  logic [tgs_pkg::CFG_DATA_W-1:0]   inv_h,
  output logic                             rdy,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [tgs_pkg::NRES*tgs_pkg::OUT_W-1:0] res_data,
  output logic                             res_last
);
  import tgs_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic r1, r2, r3, r4, r5;

  sten_t s1_r;
  logic  l2_r, l3_r, l4_r, l5_r;

  logic signed [DIFF_W-1:0] d2_r [9];
  logic signed [LAP_W-1:0]  lap2_r;
  logic signed [PROD_W-1:0] p3_r [9];
  logic signed [LAPQ_W-1:0] lapq3_r;
  logic signed [OUT_W-1:0]  o4_r [9];
  logic signed [SAT_IN_W-1:0] lapqq4_r;
  logic signed [OUT_W-1:0]  o5_r [NRES];

  logic signed [Q_W-1:0] qs;
  assign qs = $signed({1'b0, inv_h});

  assign r5  = !v5_r || res_ready;
  assign r4  = !v4_r || r5;
  assign r3  = !v3_r || r4;
  assign r2  = !v2_r || r3;
  assign r1  = !v1_r || r2;
  assign rdy = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (r1) v1_r <= load && emit;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
    end
  end

  // order of the nine differences: central x y z, forward x y z, backward x y z
  always_ff @(posedge clk) begin
    if (r1) begin
      s1_r <= sten;
    end
    if (r2) begin
      l2_r    <= s1_r.last;
      d2_r[0] <= DIFF_W'(s1_r.xp) - DIFF_W'(s1_r.xm);
      d2_r[1] <= DIFF_W'(s1_r.yp) - DIFF_W'(s1_r.ym);
      d2_r[2] <= DIFF_W'(s1_r.zp) - DIFF_W'(s1_r.zm);
      d2_r[3] <= DIFF_W'(s1_r.xp) - DIFF_W'(s1_r.c);
      d2_r[4] <= DIFF_W'(s1_r.yp) - DIFF_W'(s1_r.c);
      d2_r[5] <= DIFF_W'(s1_r.zp) - DIFF_W'(s1_r.c);
      d2_r[6] <= DIFF_W'(s1_r.c) - DIFF_W'(s1_r.xm);
      d2_r[7] <= DIFF_W'(s1_r.c) - DIFF_W'(s1_r.ym);
      d2_r[8] <= DIFF_W'(s1_r.c) - DIFF_W'(s1_r.zm);
      lap2_r  <= LAP_W'(s1_r.xp) + LAP_W'(s1_r.xm) + LAP_W'(s1_r.yp)
               + LAP_W'(s1_r.ym) + LAP_W'(s1_r.zp) + LAP_W'(s1_r.zm)
               - (LAP_W'(s1_r.c) <<< 2) - (LAP_W'(s1_r.c) <<< 1);
    end
    if (r3) begin
      l3_r <= l2_r;
      for (int i = 0; i < 9; i++) begin
        p3_r[i] <= PROD_W'(d2_r[i]) * PROD_W'(qs);
      end
      lapq3_r <= LAPQ_W'(lap2_r) * LAPQ_W'(qs);
    end
    if (r4) begin
      l4_r <= l3_r;
      for (int i = 0; i < 3; i++) begin
        o4_r[i] <= sat32(SAT_IN_W'(p3_r[i] >>> 1));
      end
      for (int i = 3; i < 9; i++) begin
        o4_r[i] <= sat32(SAT_IN_W'(p3_r[i]));
      end
      lapqq4_r <= SAT_IN_W'(lapq3_r) * SAT_IN_W'(qs);
    end
    if (r5) begin
      l5_r <= l4_r;
      for (int i = 0; i < 9; i++) begin
        o5_r[i] <= o4_r[i];
      end
      o5_r[9] <= sat32(lapqq4_r >>> LAP_SHIFT);
    end
  end

  always_comb begin
    for (int i = 0; i < NRES; i++) begin
      res_data[i*OUT_W +: OUT_W] = o5_r[i];
    end
  end

  assign res_valid = v5_r;
  assign res_last  = l5_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !r1 |-> v1_r && v2_r && v3_r && v4_r && v5_r)
    else $error("input held off with a bubble in the pipeline");

  a_no_load_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> r1)
    else $error("item taken while stage one full");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && v5_r && !res_ready |=> v4_r && $stable(l4_r))
    else $error("stage four lost an item under stall");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tgs_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 12;

  // Tracks the stencil window, predicts the result item of each accepted input
  // that reports a voxel and checks results against the oldest prediction.
  class stencil_scoreboard;
    logic [31:0] window [0:2*MAX_SIDE*MAX_SIDE];
    int unsigned received;
    int unsigned pos_x, pos_y, pos_z;
    int unsigned side;
    longint      inv_h;
    logic [NRES*OUT_W-1:0] want_data [$];
    logic                  want_last [$];
    int errors;
    int checked;
    int frames;

    function new();
      side = MAX_SIDE;
      inv_h = 256;
      restart();
    endfunction

    function void restart();
      received = 0;
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      int unsigned s;
      if (idx == CFG_GRID_SIDE) begin
        s = data & 63;
        if (s < SIDE_MIN) s = SIDE_MIN;
        if (s > MAX_SIDE) s = MAX_SIDE;
        side = s;
        restart();
      end else begin
        inv_h = data;
      end
    endfunction

    function longint temp_at(int unsigned lin, int unsigned depth);
      return longint'($signed(window[lin % depth][15:0]));
    endfunction

    function logic [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void predict_voxel(int unsigned plane, int unsigned depth);
      int unsigned o;
      longint c, amb, xp, xm, yp, ym, zp, zm, lap;
      logic [NRES*OUT_W-1:0] r;
      logic last;
      o = pos_z * plane + pos_y * side + pos_x;
      c = longint'($signed(window[o % depth][15:0]));
      amb = longint'($signed(window[o % depth][31:16]));
      xp = (pos_x + 1 < side) ? temp_at(o + 1, depth) : amb;
      xm = (pos_x > 0) ? temp_at(o - 1, depth) : amb;
      yp = (pos_y + 1 < side) ? temp_at(o + side, depth) : amb;
      ym = (pos_y > 0) ? temp_at(o - side, depth) : amb;
      zp = (pos_z + 1 < side) ? temp_at(o + plane, depth) : amb;
      zm = (pos_z > 0) ? temp_at(o - plane, depth) : amb;
      lap = xp + xm + yp + ym + zp + zm - 6 * c;
      r[0*32 +: 32] = clip(((xp - xm) * inv_h) >>> 1);
      r[1*32 +: 32] = clip(((yp - ym) * inv_h) >>> 1);
      r[2*32 +: 32] = clip(((zp - zm) * inv_h) >>> 1);
      r[3*32 +: 32] = clip((xp - c) * inv_h);
      r[4*32 +: 32] = clip((yp - c) * inv_h);
      r[5*32 +: 32] = clip((zp - c) * inv_h);
      r[6*32 +: 32] = clip((c - xm) * inv_h);
      r[7*32 +: 32] = clip((c - ym) * inv_h);
      r[8*32 +: 32] = clip((c - zm) * inv_h);
      r[9*32 +: 32] = clip((lap * inv_h * inv_h) >>> LAP_SHIFT);
      last = (o == plane * side - 1);
      want_data.push_back(r);
      want_last.push_back(last);
      if (last) begin
        frames++;
        restart();
        return;
      end
      pos_x++;
      if (pos_x == side) begin
        pos_x = 0;
        pos_y++;
        if (pos_y == side) begin
          pos_y = 0;
          pos_z++;
        end
      end
    endfunction

    function void note_input(op_t op, logic [31:0] word);
      int unsigned plane = side * side;
      int unsigned total = plane * side;
      int unsigned depth = 2 * plane + 1;
      int unsigned n = received;
      if (op == OP_SAMPLE) begin
        if (n >= total) return;
        window[n % depth] = word;
        received = n + 1;
        if (n < plane) return;
        predict_voxel(plane, depth);
      end else if (received == total) begin
        predict_voxel(plane, depth);
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [NRES*OUT_W-1:0] data, logic last);
      string names [NRES] = '{"central_dx", "central_dy", "central_dz", "forward_dx",
        "forward_dy", "forward_dz", "backward_dx", "backward_dy", "backward_dz",
        "laplacian"};
      logic [NRES*OUT_W-1:0] w;
      logic wl;
      if (want_data.size() == 0) begin
        report_mismatch("unexpected result item", data[31:0], 32'h0);
        return;
      end
      w = want_data.pop_front();
      wl = want_last.pop_front();
      checked++;
      for (int i = 0; i < NRES; i++)
        if (data[i*32 +: 32] !== w[i*32 +: 32])
          report_mismatch(names[i], data[i*32 +: 32], w[i*32 +: 32]);
      if (last !== wl) report_mismatch("last_of_frame", 32'(last), 32'(wl));
    endtask

    function int pending();
      return want_data.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [NRES*OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stencil_scoreboard sb = new();
  int idle_cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int ready_left = 0;
  int ready_phase = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  temperature_gradient_stencil u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("** temperature_gradient_stencil: FAILED **");
        $finish;
      end
    end
  end

  // receiver: stall pattern switches between always ready, random and periodic
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 300);
    end
    ready_left--;
    ready_phase = (ready_phase + 1) % 5;
    case (ready_mode)
      0: out_tready = 1'b1;
      1: out_tready = ($urandom % 4) != 0;
      default: out_tready = ready_phase < 3;
    endcase
  end

  task automatic send_item(op_t op, logic [15:0] temp, logic [15:0] amb);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom % 4 == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {amb, temp};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_wait();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_temp();
    case ($urandom % 8)
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One frame with noise: stray flushes before the grid is complete, stray
  // samples while it drains, extra flushes after the last voxel.
  task automatic send_frame(int side, bit extremes, bit hold_mid);
    int total = side * side * side;
    logic [15:0] t;
    for (int i = 0; i < total; i++) begin
      if ($urandom % 10 == 0) send_item(OP_FLUSH, rand_temp(), rand_temp());
      if (hold_mid && i == total / 2) drain_wait();
      t = ((i + i / side + i / (side * side)) % 2) ? 16'h7FFF : 16'h8000;
      if (extremes) send_item(OP_SAMPLE, t, ~t);
      else send_item(OP_SAMPLE, rand_temp(), rand_temp());
    end
    for (int i = 0; i < side * side; i++) begin
      if ($urandom % 8 == 0) send_item(OP_SAMPLE, rand_temp(), rand_temp());
      send_item(OP_FLUSH, rand_temp(), rand_temp());
    end
    repeat ($urandom_range(0, 2)) send_item(OP_FLUSH, rand_temp(), rand_temp());
  endtask

  initial begin
    int side;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: clamped small side, largest and zero scale, extreme checkerboard, mid-frame drain
    write_reg(CFG_GRID_SIDE, 16'd2);
    write_reg(CFG_INV_CELL, 16'hFFFF);
    send_frame(3, 1'b1, 1'b0);
    drain_wait();
    write_reg(CFG_INV_CELL, 16'h0000);
    send_frame(3, 1'b0, 1'b0);
    drain_wait();
    write_reg(CFG_GRID_SIDE, 16'd4);
    write_reg(CFG_INV_CELL, 16'h0001);
    send_frame(4, 1'b0, 1'b1);
    drain_wait();

    // abandoned frame: a side write mid-frame restarts it
    write_reg(CFG_GRID_SIDE, 16'd5);
    for (int i = 0; i < 40; i++) send_item(OP_SAMPLE, rand_temp(), rand_temp());
    drain_wait();

    while (items_sent < 1100) begin
      side = $urandom_range(3, 7);
      write_reg(CFG_GRID_SIDE, 16'(side) | (16'($urandom) & 16'hFFC0));
      write_reg(CFG_INV_CELL, ($urandom % 4 == 0) ? 16'hFFFF : 16'($urandom));
      repeat ($urandom_range(1, 2)) send_frame(side, 1'b0, 1'b0);
      drain_wait();
    end

    // a side above the maximum clamps to it; the frame is cut short by the
    // next side write, which must restart cleanly
    write_reg(CFG_GRID_SIDE, 16'd63);
    write_reg(CFG_INV_CELL, 16'd256);
    for (int i = 0; i < 60; i++) send_item(OP_SAMPLE, rand_temp(), rand_temp());
    drain_wait();
    write_reg(CFG_GRID_SIDE, 16'd3);
    send_frame(3, 1'b0, 1'b0);
    drain_wait();

    $display("covered %0d input items, %0d result items checked over %0d frames",
             items_sent, sb.checked, sb.frames);
    $display("sides 3 to 7 plus a clamped side of %0d, scales 0 to 0xFFFF, stray items, stalls",
             MAX_SIDE);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** temperature_gradient_stencil: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("** temperature_gradient_stencil: FAILED **");
    end
    $finish;
  end

endmodule
